@@ rtl/skph_pkg.sv @@
// Shared types, constants and key decoding for the serial key to gamepad block.
package skph_pkg;

   // Result mask width is fixed by the button layout.
   localparam int MASK_W = 10;
   localparam int HOLD_W = 16;
   localparam int BIT_W  = 4;

   localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd250;

   // Request command codes.
   localparam logic CMD_KEY  = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Special characters.
   localparam logic [7:0] CHAR_ESC      = 8'h1B;
   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;

   // Button positions in the mask.
   localparam logic [BIT_W-1:0] BTN_A      = 4'd0;
   localparam logic [BIT_W-1:0] BTN_B      = 4'd1;
   localparam logic [BIT_W-1:0] BTN_SELECT = 4'd2;
   localparam logic [BIT_W-1:0] BTN_START  = 4'd3;
   localparam logic [BIT_W-1:0] BTN_UP     = 4'd4;
   localparam logic [BIT_W-1:0] BTN_DOWN   = 4'd5;
   localparam logic [BIT_W-1:0] BTN_LEFT   = 4'd6;
   localparam logic [BIT_W-1:0] BTN_RIGHT  = 4'd7;
   localparam logic [BIT_W-1:0] BTN_X      = 4'd8;
   localparam logic [BIT_W-1:0] BTN_Y      = 4'd9;

   // Escape sequence parser state.
   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_ESC  = 3'b010,
      PH_CSI  = 3'b100
   } phase_type;

   typedef struct packed {
      logic             hit;
      logic [BIT_W-1:0] idx;
   } press_type;

   // Key map outside an escape sequence.
   function automatic press_type plain_key(input logic [7:0] c);
      press_type p;
      p.hit = 1'b1;
      p.idx = BTN_A;
      case (c) inside
         "w", "W":           p.idx = BTN_UP;
         "s", "S":           p.idx = BTN_DOWN;
         "a", "A":           p.idx = BTN_LEFT;
         "d", "D":           p.idx = BTN_RIGHT;
         "k", "K", "z", "Z": p.idx = BTN_A;
         "j", "J", "x", "X": p.idx = BTN_B;
         "u", "U":           p.idx = BTN_X;
         "i", "I":           p.idx = BTN_Y;
         8'h0D, 8'h0A:       p.idx = BTN_START;
         8'h09:              p.idx = BTN_SELECT;
         default:            p.hit = 1'b0;
      endcase
      return p;
   endfunction

   // Final byte of an ESC [ arrow sequence.
   function automatic press_type arrow_key(input logic [7:0] c);
      press_type p;
      p.hit = 1'b1;
      p.idx = BTN_UP;
      case (c)
         "A":     p.idx = BTN_UP;
         "B":     p.idx = BTN_DOWN;
         "C":     p.idx = BTN_RIGHT;
         "D":     p.idx = BTN_LEFT;
         default: p.hit = 1'b0;
      endcase
      return p;
   endfunction

endpackage

@@ rtl/skph_req_if.sv @@
// Request channel: one key byte or one time tick per request.
interface skph_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] key_byte;

   modport source (output valid, output cmd, output key_byte, input ready);
   modport sink   (input valid, input cmd, input key_byte, output ready);
endinterface

@@ rtl/skph_rsp_if.sv @@
// Response channel: the button mask after each request.
interface skph_rsp_if
   import skph_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [MASK_W-1:0] button_mask;

   modport source (output valid, output button_mask, input ready);
   modport sink   (input valid, input button_mask, output ready);
endinterface

@@ rtl/serial_key_to_pad_hold.sv @@
// Top level: terminal key bytes and ticks in, held gamepad button mask out.
//
//   channel   direction  handshake        payload
//   req_port  in         valid / ready    cmd (1), key_byte (8)
//   rsp_port  out        valid / ready    button_mask (10)
//   csr       in         csr_wr_en        csr_wr_data (16) = hold time in ticks
//
// Every request produces exactly one response. A request is captured in the
// input register; then, once the response register is empty or draining, the
// parser and all countdowns are updated and the new mask is loaded into the
// response register, which offers it. One request per cycle is sustained
// while responses are taken without a stall, and the rate is set by the
// single update step between the two registers.
// A stalled response holds the update step; the input register still takes
// a request while it is empty. Reset is synchronous and clears the parser,
// every countdown and both valid flags, and restores a hold time of 250.
module serial_key_to_pad_hold
   import skph_pkg::*;
#(
   parameter int BUTTONS = 10
) (
   input  logic              clock,
   input  logic              reset,
   skph_req_if.sink          req_port,
   skph_rsp_if.source        rsp_port,
   input  logic              csr_wr_en,
   input  logic [HOLD_W-1:0] csr_wr_data
);

   // Hold time register.
   logic [HOLD_W-1:0] hold_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff <= HOLD_RESET;
      end else if (csr_wr_en) begin
         hold_ticks_ff <= csr_wr_data;
      end
   end

   // Input register stage.
   logic       in_valid_ff;
   logic       in_cmd_ff;
   logic [7:0] in_key_ff;
   logic       rsp_valid_ff;
   logic       advance;

   // The update step runs when a request is staged and the response register
   // is empty or is being drained in this cycle.
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_port.ready);
   assign req_port.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_port.ready) begin
         in_valid_ff <= req_port.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_port.valid && req_port.ready) begin
         in_cmd_ff <= req_port.cmd;
         in_key_ff <= req_port.key_byte;
      end
   end

   // Escape sequence parser. A byte after ESC is consumed: only '[' moves on.
   // The byte after ESC [ is consumed as well and may press an arrow.
   phase_type phase_ff;
   phase_type phase_in;
   press_type press;
   logic      clear_all;

   always_comb begin
      phase_in  = phase_ff;
      press     = '0;
      clear_all = 1'b0;
      if (in_cmd_ff == CMD_KEY) begin
         unique case (phase_ff)
            PH_ESC: begin
               phase_in = (in_key_ff == CHAR_LBRACKET) ? PH_CSI : PH_IDLE;
            end
            PH_CSI: begin
               phase_in = PH_IDLE;
               press    = arrow_key(in_key_ff);
            end
            default: begin
               phase_in = PH_IDLE;
               if (in_key_ff == CHAR_ESC) begin
                  phase_in = PH_ESC;
               end else if (in_key_ff == CHAR_SPACE) begin
                  clear_all = 1'b1;
               end else begin
                  press = plain_key(in_key_ff);
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (advance) begin
         phase_ff <= phase_in;
      end
   end

   // One countdown per button. A tick decrements every nonzero countdown, a
   // press reloads one countdown with the hold time, and a space clears all.
   logic [HOLD_W-1:0] hold_count_ff [BUTTONS];
   logic [HOLD_W-1:0] hold_count_in [BUTTONS];

   for (genvar b = 0; b < BUTTONS; b++) begin : g_count
      always_comb begin
         hold_count_in[b] = hold_count_ff[b];
         if (in_cmd_ff == CMD_TICK) begin
            if (hold_count_ff[b] != '0) begin
               hold_count_in[b] = hold_count_ff[b] - HOLD_W'(1);
            end
         end else if (clear_all) begin
            hold_count_in[b] = '0;
         end else if (press.hit && (press.idx == BIT_W'(b))) begin
            hold_count_in[b] = hold_ticks_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            hold_count_ff[b] <= '0;
         end else if (advance) begin
            hold_count_ff[b] <= hold_count_in[b];
         end
      end
   end

   // Response register. Only the first ten buttons appear in the mask.
   logic [MASK_W-1:0] mask_in;
   logic [MASK_W-1:0] rsp_mask_ff;

   always_comb begin
      for (int i = 0; i < MASK_W; i++) begin
         mask_in[i] = (hold_count_in[i] != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_mask_ff <= mask_in;
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.button_mask = rsp_mask_ff;

endmodule

@@ rtl/skph_checker.sv @@
// Port-level checks for the serial key to gamepad block, bound to the top level.
module skph_checker
   import skph_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [MASK_W-1:0] rsp_mask
);

   // Requests taken but not yet answered; the block holds at most two.
   logic [2:0] pending_ff;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 3'(req_take) - 3'(rsp_take);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_mask_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_mask))
      else $error("response mask changed while stalled");

   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("response without a pending request");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd2)
      else $error("more requests pending than the block can hold");

endmodule

bind serial_key_to_pad_hold skph_checker u_skph_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_port.valid),
   .req_ready (req_port.ready),
   .rsp_valid (rsp_port.valid),
   .rsp_ready (rsp_port.ready),
   .rsp_mask  (rsp_port.button_mask)
);
